FILE: rtl/pose_error_metric_macros.svh
// Assertion macros shared by the pose error metric RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef POSE_ERROR_METRIC_MACROS_SVH
`define POSE_ERROR_METRIC_MACROS_SVH

// same-cycle implication
`define PEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pem_pkg.sv
// Types and constants of the pose error metric.
// No dependencies.
`timescale 1ns / 1ps
package pem_pkg;
  localparam int DefFractionBits = 24;
  localparam int RadW  = 68;
  localparam int RootW = 34;
  localparam int MulW  = 34;

  localparam logic [1:0] ColTrans = 2'd3;
  localparam logic [1:0] ColFirst = 2'd0;

  typedef struct packed {
    logic              trans;
    logic [1:0]        col;
    logic signed [31:0] want_x;
    logic signed [31:0] want_y;
    logic signed [31:0] want_z;
    logic signed [31:0] got_x;
    logic signed [31:0] got_y;
    logic signed [31:0] got_z;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CROSS, ST_ACC, ST_PSQ, ST_PSQRT, ST_RSQ, ST_RSQRT, ST_OUT
  } back_st_e;
endpackage

FILE: rtl/pem_front.sv
// Front end: accepts column words, tags them and holds them in a two-entry queue.
// Depends on pem_pkg.
`timescale 1ns / 1ps
module pem_front import pem_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        column_index_i,
  input  logic signed [31:0] want_x_i,
  input  logic signed [31:0] want_y_i,
  input  logic signed [31:0] want_z_i,
  input  logic signed [31:0] got_x_i,
  input  logic signed [31:0] got_y_i,
  input  logic signed [31:0] got_z_i,
  output logic              q_valid_o,
  output item_t             q_item_o,
  input  logic              q_pop_i
);
  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      in_item;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign pop  = q_pop_i && q_valid_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_q];

  always_comb begin
    in_item.trans  = (column_index_i == ColTrans);
    in_item.col    = column_index_i;
    in_item.want_x = want_x_i;
    in_item.want_y = want_y_i;
    in_item.want_z = want_z_i;
    in_item.got_x  = got_x_i;
    in_item.got_y  = got_y_i;
    in_item.got_z  = got_z_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: rtl/pem_sqrt.sv
// Integer square root, one result bit per cycle.
// Depends on pem_pkg.
`timescale 1ns / 1ps
module pem_sqrt import pem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RadW-1:0]  rad_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);
  localparam int CntW = $clog2(RootW + 1);
  logic [RadW-1:0]  rad_q;
  logic [RootW+2:0] rem_q;
  logic [RootW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [RootW+2:0] rem_sh, trial;
  logic             fits;

  assign rem_sh = {rem_q[RootW:0], rad_q[RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RootW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/pem_back.sv
// Back end: cross products, rotation accumulator, norms and the output register.
// Depends on pem_pkg and pem_sqrt.
`timescale 1ns / 1ps
module pem_back import pem_pkg::*; #(
  parameter int FRACTION_BITS = DefFractionBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pose_error_o,
  output logic        saturated_o,
  output logic        sq_start_o,
  output logic        sq_busy_o
);
  localparam logic signed [64:0] Rnd = 65'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [64:0] Cap = 65'sd1 <<< 62;

  back_st_e st_q, st_d;
  logic [2:0] step_q, step_d;
  item_t item_q;
  logic signed [2*MulW-1:0] prod_q, tmp_q;
  logic signed [64:0] cr_q [3];
  logic signed [63:0] acc_q [3];
  logic [RadW-1:0] sum_q;
  logic [RootW-1:0] pos_q;
  logic [31:0] res_q;
  logic sat_q, out_valid_q;
  logic signed [MulW-1:0] mul_a, mul_b;
  logic signed [MulW-1:0] dif [3];
  logic issue, big, slot_free;
  logic [2:0] j;
  logic [RadW-1:0] rad;
  logic sq_done;
  logic [RootW-1:0] root;
  logic [RootW:0] total;

  pem_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start_o), .rad_i(rad),
    .busy_o(sq_busy_o), .done_o(sq_done), .root_o(root)
  );

  assign dif[0] = MulW'(item_q.want_x) - MulW'(item_q.got_x);
  assign dif[1] = MulW'(item_q.want_y) - MulW'(item_q.got_y);
  assign dif[2] = MulW'(item_q.want_z) - MulW'(item_q.got_z);
  assign j = step_q - 3'd1;
  assign rad = sum_q + RadW'(prod_q);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign total = {1'b0, pos_q} + {2'b00, root[RootW-1:1]};

  // rotation fits the output only while every component is inside +-2^33
  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!((acc_q[i][63:33] == '0) || ((acc_q[i][63:33] == '1) && (acc_q[i][32:0] != '0))))
        big = 1'b1;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      ST_CROSS: begin
        case (step_q)
          3'd0: begin mul_a = MulW'(item_q.want_y); mul_b = MulW'(item_q.got_z); end
          3'd1: begin mul_a = MulW'(item_q.want_z); mul_b = MulW'(item_q.got_y); end
          3'd2: begin mul_a = MulW'(item_q.want_z); mul_b = MulW'(item_q.got_x); end
          3'd3: begin mul_a = MulW'(item_q.want_x); mul_b = MulW'(item_q.got_z); end
          3'd4: begin mul_a = MulW'(item_q.want_x); mul_b = MulW'(item_q.got_y); end
          3'd5: begin mul_a = MulW'(item_q.want_y); mul_b = MulW'(item_q.got_x); end
          default: ;
        endcase
      end
      ST_PSQ: if (step_q < 3'd3) begin
        mul_a = dif[step_q[1:0]];
        mul_b = dif[step_q[1:0]];
      end
      ST_RSQ: if (step_q < 3'd3) begin
        mul_a = acc_q[step_q[1:0]][MulW-1:0];
        mul_b = acc_q[step_q[1:0]][MulW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    step_d = step_q;
    q_pop_o = 1'b0;
    sq_start_o = 1'b0;
    issue = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        step_d = '0;
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (!q_item_i.trans) st_d = ST_CROSS;
          else if (big)        st_d = ST_OUT;
          else                 st_d = ST_PSQ;
        end
      end
      ST_CROSS: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd6) st_d = ST_ACC;
      end
      ST_ACC: st_d = ST_IDLE;
      ST_PSQ, ST_RSQ: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd3) begin
          sq_start_o = 1'b1;
          st_d = (st_q == ST_PSQ) ? ST_PSQRT : ST_RSQRT;
        end
      end
      ST_PSQRT: begin
        step_d = '0;
        if (sq_done) st_d = ST_RSQ;
      end
      ST_RSQRT: if (sq_done) st_d = ST_OUT;
      ST_OUT: if (slot_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
    issue = (st_d != st_q) && (st_q == ST_OUT);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (q_pop_o) begin
      item_q <= q_item_i;
      if (q_item_i.trans && big) begin
        res_q <= '1;
        sat_q <= 1'b1;
      end
    end
    if (st_q == ST_CROSS && step_q != 3'd0) begin
      if (!j[0]) tmp_q <= prod_q;
      else cr_q[j[2:1]] <= tmp_q[64:0] - prod_q[64:0];
    end
    if (st_q == ST_PSQ || st_q == ST_RSQ) begin
      if (step_q == 3'd1) sum_q <= RadW'(prod_q);
      else if (step_q == 3'd2) sum_q <= rad;
    end
    if (st_q == ST_PSQRT && sq_done) pos_q <= root;
    // anything above bit 31 clamps to the max
    if (st_q == ST_RSQRT && sq_done) begin
      res_q <= (total[RootW:32] != '0) ? '1 : total[31:0];
      sat_q <= (total[RootW:32] != '0);
    end
    if (issue) begin
      pose_error_o <= res_q;
      saturated_o  <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      step_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) acc_q[i] <= '0;
    end else begin
      st_q <= st_d;
      step_q <= step_d;
      if (issue) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (st_q == ST_ACC) begin
        for (int i = 0; i < 3; i++) begin
          logic signed [64:0] r, s;
          r = (cr_q[i] + Rnd) >>> FRACTION_BITS;
          s = {acc_q[i][63], acc_q[i]} + r;
          if (item_q.col == ColFirst) acc_q[i] <= r[63:0];
          else if (s > Cap)  acc_q[i] <= Cap[63:0];
          else if (s < -Cap) acc_q[i] <= -Cap[63:0];
          else acc_q[i] <= s[63:0];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

FILE: rtl/pose_error_metric.sv
// Channel  | handshake            | payload
// input    | in_valid_i/in_stall_o | column_index_i, want_*_i, got_*_i
// output   | out_valid_o/out_stall_i | pose_error_o, saturated_o
//
// Rotation column: six products on one shared multiplier in the back end.
// Translation column: two serial square roots of 34 steps each.
// A huge rotation skips the roots.
// Reset clears the queue, the accumulator and the output valid flag; the output word is not reset.
// A two-word queue lets input words arrive while the back end works or the output stalls.
// Depends on pem_pkg, pem_front, pem_back and the macro header.
`timescale 1ns / 1ps
`include "pose_error_metric_macros.svh"
module pose_error_metric import pem_pkg::*; #(
  parameter int FRACTION_BITS = DefFractionBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        column_index_i,
  input  logic signed [31:0] want_x_i,
  input  logic signed [31:0] want_y_i,
  input  logic signed [31:0] want_z_i,
  input  logic signed [31:0] got_x_i,
  input  logic signed [31:0] got_y_i,
  input  logic signed [31:0] got_z_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       pose_error_o,
  output logic              saturated_o
);
  logic  q_valid, q_pop, sq_start, sq_busy;
  item_t q_item;

  pem_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .column_index_i,
    .want_x_i, .want_y_i, .want_z_i, .got_x_i, .got_y_i, .got_z_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  pem_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .pose_error_o, .saturated_o,
    .sq_start_o(sq_start), .sq_busy_o(sq_busy)
  );

  `PEM_ASSERT_NOW(a_sat_max, out_valid_o && saturated_o, pose_error_o == 32'hFFFF_FFFF, "saturated word not at max")
  `PEM_ASSERT_NOW(a_sqrt_free, sq_start, !sq_busy, "square root restarted while busy")
  `PEM_ASSERT_NEXT(a_sqrt_run, sq_start, sq_busy, "square root did not start")
endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for pose_error_metric: column words in, pose error words out.
// Scores each result against a behavioral predictor kept in this file.
// Depends on pem_pkg and the pose_error_metric RTL.
`timescale 1ns / 1ps
module tb;
  import pem_pkg::*;

  localparam int FracBits = DefFractionBits;
  localparam longint AccCap = 64'sd1 <<< 62;
  localparam longint RotBig = 64'sd1 <<< 33;
  localparam int Limit = 2000000;

  typedef struct {
    logic [1:0] col;
    logic signed [31:0] wx, wy, wz, gx, gy, gz;
  } column_t;

  typedef struct {
    logic [31:0] err;
    logic sat;
  } pose_err_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] column_index_i = '0;
  logic signed [31:0] want_x_i = '0, want_y_i = '0, want_z_i = '0;
  logic signed [31:0] got_x_i = '0, got_y_i = '0, got_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] pose_error_o;
  logic saturated_o;

  pose_error_metric u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  column_t pending_cols[$];
  pose_err_t expected_errs[$];
  longint signed rot_acc[3];
  int errors = 0;
  int n_results = 0;
  int n_sat = 0;
  int cycle = 0;
  bit idle_en = 1'b1;
  int hold_left = 0;
  bit drain_req = 1'b0;

  function automatic longint signed cross_round(longint signed a, b, c, d);
    longint signed v;
    v = a * b - c * d + (64'sd1 <<< (FracBits - 1));
    return v >>> FracBits;
  endfunction

  function automatic logic [63:0] mag(longint signed v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // floor(sqrt(x^2+y^2+z^2)) with 70-bit exact sum
  function automatic logic [63:0] isqrt3(logic [63:0] x, y, z);
    logic [69:0] n, c2;
    logic [63:0] r, c;
    n = 70'(x) * 70'(x) + 70'(y) * 70'(y) + 70'(z) * 70'(z);
    r = 0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (64'd1 << b);
      c2 = 70'(c) * 70'(c);
      if (c2 <= n) r = c;
    end
    return r;
  endfunction

  task automatic predict_column(column_t w);
    longint signed c[3];
    longint signed s;
    logic [63:0] total;
    pose_err_t e;
    bit big;
    if (w.col != ColTrans) begin
      c[0] = cross_round(w.wy, w.gz, w.wz, w.gy);
      c[1] = cross_round(w.wz, w.gx, w.wx, w.gz);
      c[2] = cross_round(w.wx, w.gy, w.wy, w.gx);
      for (int i = 0; i < 3; i++) begin
        if (w.col == ColFirst) rot_acc[i] = c[i];
        else begin
          s = rot_acc[i] + c[i];
          if (s > AccCap) s = AccCap;
          if (s < -AccCap) s = -AccCap;
          rot_acc[i] = s;
        end
      end
    end else begin
      big = 1'b0;
      total = 0;
      for (int i = 0; i < 3; i++)
        if (rot_acc[i] >= RotBig || rot_acc[i] <= -RotBig) big = 1'b1;
      if (!big)
        total = isqrt3(mag(64'(w.wx) - 64'(w.gx)), mag(64'(w.wy) - 64'(w.gy)),
                       mag(64'(w.wz) - 64'(w.gz)))
              + (isqrt3(mag(rot_acc[0]), mag(rot_acc[1]), mag(rot_acc[2])) >> 1);
      if (big || total > 64'hFFFF_FFFF) begin
        e.err = 32'hFFFF_FFFF;
        e.sat = 1'b1;
      end else begin
        e.err = total[31:0];
        e.sat = 1'b0;
      end
      expected_errs.push_back(e);
    end
  endtask

  function automatic logic [31:0] rand_val(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25)); // around +-2.0
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(int'($urandom_range(0, 255)) - 128);
    endcase
  endfunction

  function automatic column_t make_col(logic [1:0] col, int kind);
    column_t w;
    w.col = col;
    w.wx = rand_val(kind); w.wy = rand_val(kind); w.wz = rand_val(kind);
    w.gx = rand_val(kind); w.gy = rand_val(kind); w.gz = rand_val(kind);
    return w;
  endfunction

  function automatic column_t fill_col(logic [1:0] col, logic [31:0] a, logic [31:0] b);
    column_t w;
    w.col = col;
    w.wx = a; w.wy = a; w.wz = a;
    w.gx = b; w.gy = b; w.gz = b;
    return w;
  endfunction

  // stall as seen at the last rising edge
  logic in_stall_o_q;
  always @(posedge clk_i) in_stall_o_q <= in_stall_o;

  // driver: word presented at falling edge, accepted at rising edge
  column_t cur;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o_q) predict_column(cur);
      if (!(in_valid_i && in_stall_o_q)) begin
        if (pending_cols.size() > 0 && !drain_req &&
            !(idle_en && $urandom_range(0, 99) < 30)) begin
          cur = pending_cols.pop_front();
          in_valid_i <= 1'b1;
          column_index_i <= cur.col;
          want_x_i <= cur.wx; want_y_i <= cur.wy; want_z_i <= cur.wz;
          got_x_i <= cur.gx; got_y_i <= cur.gy; got_z_i <= cur.gz;
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else out_stall_i <= idle_en && ($urandom_range(0, 99) < 30);
  end

  // monitor
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_errs.size() == 0) begin
        $error("unexpected result word: pose_error=%h", pose_error_o);
        errors++;
      end else begin
        pose_err_t e;
        e = expected_errs.pop_front();
        if (pose_error_o !== e.err) begin
          $error("pose_error: expected %h actual %h", e.err, pose_error_o);
          errors++;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated: expected %b actual %b", e.sat, saturated_o);
          errors++;
        end
        n_results++;
        if (e.sat) n_sat++;
      end
    end
  end

  initial begin
    int kind;
    for (int i = 0; i < 3; i++) rot_acc[i] = 0;
    // directed: zero pose, extremes, missing columns, large accumulated rotation
    pending_cols.push_back(fill_col(ColTrans, 0, 0));
    pending_cols.push_back(fill_col(ColTrans, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_cols.push_back(fill_col(ColTrans, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_cols.push_back(fill_col(ColTrans, 32'hFFFF_FFFF, 32'h0000_0001));
    for (int c = 0; c < 3; c++) pending_cols.push_back(make_col(2'(c), 1));
    pending_cols.push_back(make_col(ColTrans, 1));
    pending_cols.push_back(make_col(2'd2, 3));
    pending_cols.push_back(make_col(ColTrans, 3));
    begin
      column_t w;
      w = fill_col(ColFirst, 0, 0);
      w.wx = 32'h7FFF_FFFF; w.gy = 32'h8000_0000;
      w.wy = 32'h8000_0000; w.gx = 32'h8000_0000;
      pending_cols.push_back(w);
      w.col = 2'd1;
      for (int k = 0; k < 6; k++) pending_cols.push_back(w);
      pending_cols.push_back(make_col(ColTrans, 1));
      w.col = 2'd2;
      pending_cols.push_back(w);
      pending_cols.push_back(make_col(ColTrans, 0));
    end
    pending_cols.push_back(fill_col(ColFirst, 32'h0100_0000, 32'h0100_0000));
    pending_cols.push_back(fill_col(ColTrans, 32'h0100_0000, 32'h0000_0000));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    for (int p = 0; p < 125; p++) begin
      kind = $urandom_range(0, 9);
      kind = kind < 5 ? 1 : kind < 7 ? 3 : kind < 9 ? 0 : 2;
      if ($urandom_range(0, 9) < 8) begin
        for (int c = 0; c < 4; c++) pending_cols.push_back(make_col(2'(c), kind));
      end else begin
        repeat ($urandom_range(1, 5))
          pending_cols.push_back(make_col(2'($urandom_range(0, 3)), kind));
      end
      // long output hold while the sender keeps offering words
      if (p == 30) hold_left = 400;
      if (p == 60) begin
        wait (pending_cols.size() == 0);
        drain_req = 1'b1;
        wait (expected_errs.size() == 0 && !in_valid_i);
        repeat (20) @(posedge clk_i);
        drain_req = 1'b0;
      end
      if (p == 70) idle_en = 1'b0;
      if (p == 90) begin
        wait (pending_cols.size() == 0);
        idle_en = 1'b1;
      end
    end
    wait (pending_cols.size() == 0 && !in_valid_i);
    wait (expected_errs.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Checked %0d pose results (%0d saturated) over random and directed columns,",
             n_results, n_sat);
    $display("including missing columns, large rotations, a long output hold and a drain.");
    if (errors == 0 && expected_errs.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    wait (cycle >= Limit);
    $display("Regression FAIL");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/pem_pkg.sv
rtl/pem_front.sv
rtl/pem_sqrt.sv
rtl/pem_back.sv
rtl/pose_error_metric.sv
tb/sv/tb.sv
